/* rtl/core/jsop_pkg.sv */
// Shared types, codes and helpers for the flat JSON string-object parser.
`timescale 1ns / 1ps

package jsop_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int RES_IDX_W   = 2;
    localparam int RES_CNT_W   = 3;
    localparam int QUEUE_DEPTH = 4;

    // Character codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_ESC_B  = 8'h62;
    localparam logic [7:0] CH_ESC_F  = 8'h66;
    localparam logic [7:0] CH_ESC_N  = 8'h6e;
    localparam logic [7:0] CH_ESC_R  = 8'h72;
    localparam logic [7:0] CH_ESC_T  = 8'h74;
    localparam logic [7:0] CH_ESC_U  = 8'h75;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0c;

    // UTF-8 framing
    localparam logic [7:0] UTF8_LEAD2 = 8'hc0;
    localparam logic [7:0] UTF8_LEAD3 = 8'he0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;

    typedef enum logic [3:0] {
        PH_OPEN      = 4'd0,
        PH_FIRST     = 4'd1,
        PH_KEY       = 4'd2,
        PH_KEY_ESC   = 4'd3,
        PH_KEY_HEX   = 4'd4,
        PH_COLON     = 4'd5,
        PH_VAL_QUOTE = 4'd6,
        PH_VAL       = 4'd7,
        PH_VAL_ESC   = 4'd8,
        PH_VAL_HEX   = 4'd9,
        PH_SEP       = 4'd10,
        PH_KEY_QUOTE = 4'd11,
        PH_CLOSED    = 4'd12,
        PH_FAILED    = 4'd13
    } phase_t;

    typedef enum logic [2:0] {
        K_KEY_BYTE = 3'd0,
        K_VAL_BYTE = 3'd1,
        K_KEY_END  = 3'd2,
        K_VAL_END  = 3'd3,
        K_COMMIT   = 3'd4,
        K_OK       = 3'd5,
        K_ERROR    = 3'd6
    } kind_t;

    // All results caused by one input item
    typedef struct packed {
        logic [RES_CNT_W-1:0]               cnt;
        logic [MAX_RESULTS-1:0][2:0]        kind;
        logic [MAX_RESULTS-1:0][7:0]        data;
    } bundle_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

/* rtl/core/jsop_front.sv */
// Front end: grammar state machine that turns one input item into a result bundle.
`timescale 1ns / 1ps

module jsop_front import jsop_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       take,
    input  logic [7:0] in_byte,
    input  logic       byte_present,
    input  logic       end_of_text,
    output bundle_t    bundle
);

    phase_t      phase_reg, phase_next;
    logic [11:0] hex_reg, hex_next;
    logic [1:0]  hcnt_reg, hcnt_next;

    phase_t               ph_byte;
    logic [RES_CNT_W-1:0] nb;
    logic [4:0]           hd;
    logic [15:0]          cp;
    logic                 in_val;
    logic [2:0]           dk;
    phase_t               base;

    assign hd     = hex_digit(in_byte);
    assign cp     = {hex_reg, hd[3:0]};
    assign in_val = (phase_reg == PH_VAL) || (phase_reg == PH_VAL_ESC)
                  || (phase_reg == PH_VAL_HEX);
    assign dk     = in_val ? K_VAL_BYTE : K_KEY_BYTE;
    assign base   = in_val ? PH_VAL : PH_KEY;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_OPEN;
            hex_reg   <= '0;
            hcnt_reg  <= '0;
        end else if (take) begin
            phase_reg <= phase_next;
            hex_reg   <= hex_next;
            hcnt_reg  <= hcnt_next;
        end
    end

    always_comb begin
        ph_byte   = phase_reg;
        hex_next  = hex_reg;
        hcnt_next = hcnt_reg;
        nb        = '0;
        bundle    = '0;

        if (byte_present) begin
            unique case (phase_reg)
                PH_OPEN: begin
                    if (in_byte == CH_LBRACE) begin
                        ph_byte = PH_FIRST;
                    end else if (!is_ws(in_byte)) begin
                        ph_byte = PH_FAILED;
                        bundle.kind[0] = K_ERROR;
                        nb = 3'd1;
                    end
                end
                PH_FIRST: begin
                    if (in_byte == CH_RBRACE) begin
                        ph_byte = PH_CLOSED;
                    end else if (in_byte == CH_QUOTE) begin
                        ph_byte = PH_KEY;
                    end else if (!is_ws(in_byte)) begin
                        ph_byte = PH_FAILED;
                        bundle.kind[0] = K_ERROR;
                        nb = 3'd1;
                    end
                end
                PH_KEY_QUOTE, PH_VAL_QUOTE: begin
                    if (in_byte == CH_QUOTE) begin
                        ph_byte = (phase_reg == PH_KEY_QUOTE) ? PH_KEY : PH_VAL;
                    end else if (!is_ws(in_byte)) begin
                        ph_byte = PH_FAILED;
                        bundle.kind[0] = K_ERROR;
                        nb = 3'd1;
                    end
                end
                PH_COLON: begin
                    if (in_byte == CH_COLON) begin
                        ph_byte = PH_VAL_QUOTE;
                    end else if (!is_ws(in_byte)) begin
                        ph_byte = PH_FAILED;
                        bundle.kind[0] = K_ERROR;
                        nb = 3'd1;
                    end
                end
                PH_SEP: begin
                    if (in_byte == CH_COMMA || in_byte == CH_RBRACE) begin
                        ph_byte = (in_byte == CH_COMMA) ? PH_KEY_QUOTE : PH_CLOSED;
                        bundle.kind[0] = K_COMMIT;
                        nb = 3'd1;
                    end else if (!is_ws(in_byte)) begin
                        ph_byte = PH_FAILED;
                        bundle.kind[0] = K_ERROR;
                        nb = 3'd1;
                    end
                end
                PH_CLOSED: begin
                    if (!is_ws(in_byte)) begin
                        ph_byte = PH_FAILED;
                        bundle.kind[0] = K_ERROR;
                        nb = 3'd1;
                    end
                end
                PH_KEY, PH_VAL: begin
                    nb = 3'd1;
                    if (in_byte == CH_QUOTE) begin
                        ph_byte = in_val ? PH_SEP : PH_COLON;
                        bundle.kind[0] = in_val ? K_VAL_END : K_KEY_END;
                    end else if (in_byte == CH_BSLASH) begin
                        ph_byte = in_val ? PH_VAL_ESC : PH_KEY_ESC;
                        nb = '0;
                    end else begin
                        bundle.kind[0] = dk;
                        bundle.data[0] = in_byte;
                    end
                end
                PH_KEY_ESC, PH_VAL_ESC: begin
                    ph_byte = base;
                    bundle.kind[0] = dk;
                    nb = 3'd1;
                    case (in_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: bundle.data[0] = in_byte;
                        CH_ESC_B: bundle.data[0] = CH_BS;
                        CH_ESC_F: bundle.data[0] = CH_FF;
                        CH_ESC_N: bundle.data[0] = CH_LF;
                        CH_ESC_R: bundle.data[0] = CH_CR;
                        CH_ESC_T: bundle.data[0] = CH_TAB;
                        CH_ESC_U: begin
                            ph_byte   = in_val ? PH_VAL_HEX : PH_KEY_HEX;
                            hex_next  = '0;
                            hcnt_next = '0;
                            bundle.kind[0] = K_KEY_BYTE;
                            nb = '0;
                        end
                        default: begin
                            ph_byte = PH_FAILED;
                            bundle.kind[0] = K_ERROR;
                        end
                    endcase
                end
                PH_KEY_HEX, PH_VAL_HEX: begin
                    if (!hd[4]) begin
                        ph_byte = PH_FAILED;
                        bundle.kind[0] = K_ERROR;
                        nb = 3'd1;
                    end else if (hcnt_reg == 2'd3) begin
                        // Fourth digit: emit the code point as UTF-8
                        ph_byte   = base;
                        hex_next  = '0;
                        hcnt_next = '0;
                        bundle.kind[0] = dk;
                        bundle.kind[1] = dk;
                        bundle.kind[2] = dk;
                        if (cp < 16'h0080) begin
                            bundle.data[0] = cp[7:0];
                            nb = 3'd1;
                        end else if (cp < 16'h0800) begin
                            bundle.data[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
                            bundle.data[1] = UTF8_CONT | {2'b00, cp[5:0]};
                            nb = 3'd2;
                        end else begin
                            bundle.data[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
                            bundle.data[1] = UTF8_CONT | {2'b00, cp[11:6]};
                            bundle.data[2] = UTF8_CONT | {2'b00, cp[5:0]};
                            nb = 3'd3;
                        end
                    end else begin
                        hex_next  = cp[11:0];
                        hcnt_next = hcnt_reg + 2'd1;
                    end
                end
                default: begin
                    // Failed and unused codes: drop the byte
                end
            endcase
        end

        phase_next = ph_byte;
        if (end_of_text) begin
            if (ph_byte == PH_CLOSED) begin
                bundle.kind[nb[RES_IDX_W-1:0]] = K_OK;
                bundle.data[nb[RES_IDX_W-1:0]] = '0;
                nb = nb + 3'd1;
            end else if (ph_byte != PH_FAILED) begin
                bundle.kind[nb[RES_IDX_W-1:0]] = K_ERROR;
                bundle.data[nb[RES_IDX_W-1:0]] = '0;
                nb = nb + 3'd1;
            end
            phase_next = PH_OPEN;
            hex_next   = '0;
            hcnt_next  = '0;
        end
        bundle.cnt = nb;
    end

endmodule

/* rtl/core/jsop_queue.sv */
// Short bundle queue between the parser front end and the result serializer.
`timescale 1ns / 1ps

module jsop_queue import jsop_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    not_empty,
    output bundle_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bundle_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)  rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

/* rtl/core/jsop_back.sv */
// Back end: walks the head bundle and hands out one result per transfer.
`timescale 1ns / 1ps

module jsop_back import jsop_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_not_empty,
    input  bundle_t    q_head,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_result_kind,
    output logic [7:0] m_out_byte,
    output logic       m_run_last
);

    logic [RES_IDX_W-1:0] idx_reg, idx_next;
    logic                 xfer;

    assign m_valid       = q_not_empty;
    assign m_result_kind = q_head.kind[idx_reg];
    assign m_out_byte    = q_head.data[idx_reg];
    assign m_run_last    = ({1'b0, idx_reg} + RES_CNT_W'(1)) == q_head.cnt;
    assign xfer          = m_valid && m_ready;
    assign q_pop         = xfer && m_run_last;

    always_comb begin
        idx_next = idx_reg;
        if (xfer) begin
            idx_next = m_run_last ? '0 : idx_reg + RES_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

endmodule

/* rtl/core/json_string_object_parser_core.sv */
// Top level of the flat JSON string-object parser: front end, bundle queue, serializer.
// Throughput: one text byte per cycle on s_ while the queue has room; results leave at
//   one per cycle on m_ while m_ready is high; an item's k results take k transfers.
// An item's results are registered in the queue and offered once earlier bundles have left.
// Queue depth (QUEUE_DEPTH bundles) sets how long a stalled m_ side can absorb input.
// Reset (aresetn low, synchronous): parser to expect-opening-brace, queue emptied.
`timescale 1ns / 1ps

module json_string_object_parser_core import jsop_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_byte_present,
    input  logic       s_end_of_text,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_result_kind,
    output logic [7:0] m_out_byte,
    output logic       m_run_last
);

    bundle_t front_bundle;
    bundle_t q_head;
    logic    q_full;
    logic    q_not_empty;
    logic    q_pop;
    logic    take;
    logic    push;

    // Accept whenever the queue can hold a bundle; parser state advances on every transfer.
    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;
    // Drop empty bundles: items causing no results never reach the back end.
    assign push    = take && (front_bundle.cnt != '0);

    jsop_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .take         (take),
        .in_byte      (s_in_byte),
        .byte_present (s_byte_present),
        .end_of_text  (s_end_of_text),
        .bundle       (front_bundle)
    );

    jsop_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_bundle),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    jsop_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_not_empty   (q_not_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_out_byte    (m_out_byte),
        .m_run_last    (m_run_last)
    );

    // A final status always closes the results of its item.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_kind == K_OK || m_result_kind == K_ERROR)) |-> m_run_last)
        else $error("final status not marked last");

    // Only key and value bytes carry data.
    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind != K_KEY_BYTE && m_result_kind != K_VAL_BYTE)
        |-> (m_out_byte == 8'h00))
        else $error("nonzero data on a mark result");

    // A non-final result transfer leaves another result of the same bundle pending.
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_run_last) |=> m_valid)
        else $error("bundle ended without a last result");

endmodule

/* dv/json_string_object_parser_core_tb.sv */
// Self-checking testbench for the flat JSON string-object parser core.
`timescale 1ns / 1ps

module json_string_object_parser_core_tb;

    import jsop_pkg::*;

    // Cycles without any transfer before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // Minimum items per random phase, four phases in all
    localparam int PHASE_ITEMS = 75;
    // Cycles to watch for stray results once nothing is pending
    localparam int DRAIN_CYCLES = 8;

    // One result transfer on m_
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    // One row of the directed table; typed rows carry their expected result
    typedef struct packed {
        logic [7:0] b;
        logic       p;
        logic       e;
        logic       typed;
        logic       has;
        kind_t      k;
        logic [7:0] d;
    } drow_t;

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte      = 8'h00;
    logic       s_byte_present = 1'b0;
    logic       s_end_of_text  = 1'b0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic [2:0] m_result_kind;
    logic [7:0] m_out_byte;
    logic       m_run_last;

    // Grammar tracker state, mirrors what the block must hold between bytes
    phase_t      gram_ph;
    logic [15:0] uhex_acc;
    logic [1:0]  uhex_cnt;

    result_t    step_results[$];     // results of the item being predicted
    result_t    pending_results[$];  // results not yet seen on m_
    drow_t      dir_rows[$];
    logic [7:0] text_q[$];           // bytes of the text being generated

    int src_idle_pct    = 0;
    int snk_stall_pct   = 0;
    int fail_cnt        = 0;
    int items_accepted  = 0;
    int texts_sent      = 0;
    int results_checked = 0;
    int ok_seen         = 0;
    int err_seen        = 0;
    int quiet_cycles    = 0;

    json_string_object_parser_core u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_byte_present (s_byte_present),
        .s_end_of_text  (s_end_of_text),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_out_byte     (m_out_byte),
        .m_run_last     (m_run_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Grammar tracker
    // ------------------------------------------------------------------

    // Append one result; the block never emits more than MAX_RESULTS per item
    function automatic void add_result(input kind_t k, input logic [7:0] d);
        result_t r;
        r.kind = k;
        r.data = d;
        r.last = 1'b0;
        if (step_results.size() < MAX_RESULTS) begin
            step_results = {step_results, r};
        end
    endfunction

    // Enter the dropping state and flag the offending byte
    function automatic void grammar_error();
        gram_ph = PH_FAILED;
        add_result(K_ERROR, 8'h00);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic void clear_tracker();
        gram_ph  = PH_OPEN;
        uhex_acc = 16'h0000;
        uhex_cnt = 2'd0;
    endfunction

    // One byte inside a key or a value: plain, after a backslash, or a \u digit
    function automatic void string_byte(input logic [7:0] c, input logic in_value);
        phase_t      body_ph;
        phase_t      esc_ph;
        kind_t       data_k;
        logic [4:0]  nib;
        logic [15:0] cp;
        body_ph = in_value ? PH_VAL : PH_KEY;
        esc_ph  = in_value ? PH_VAL_ESC : PH_KEY_ESC;
        data_k  = in_value ? K_VAL_BYTE : K_KEY_BYTE;
        if (gram_ph == body_ph) begin
            if (c == CH_QUOTE) begin
                gram_ph = in_value ? PH_SEP : PH_COLON;
                add_result(in_value ? K_VAL_END : K_KEY_END, 8'h00);
            end else if (c == CH_BSLASH) begin
                gram_ph = esc_ph;
            end else begin
                add_result(data_k, c);
            end
        end else if (gram_ph == esc_ph) begin
            gram_ph = body_ph;
            case (c)
                CH_QUOTE, CH_BSLASH, CH_SLASH: add_result(data_k, c);
                CH_ESC_B: add_result(data_k, CH_BS);
                CH_ESC_F: add_result(data_k, CH_FF);
                CH_ESC_N: add_result(data_k, CH_LF);
                CH_ESC_R: add_result(data_k, CH_CR);
                CH_ESC_T: add_result(data_k, CH_TAB);
                CH_ESC_U: begin
                    gram_ph  = in_value ? PH_VAL_HEX : PH_KEY_HEX;
                    uhex_acc = 16'h0000;
                    uhex_cnt = 2'd0;
                end
                default: grammar_error();
            endcase
        end else begin
            // {valid, value} of a hex digit of either case
            if (c >= 8'h30 && c <= 8'h39) begin
                nib = {1'b1, c[3:0]};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                nib = {1'b1, 4'(c - 8'h37)};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                nib = {1'b1, 4'(c - 8'h57)};
            end else begin
                nib = 5'd0;
            end
            if (!nib[4]) begin
                grammar_error();
            end else begin
                cp = {uhex_acc[11:0], nib[3:0]};
                if (uhex_cnt == 2'd3) begin
                    uhex_acc = 16'h0000;
                    uhex_cnt = 2'd0;
                    gram_ph  = body_ph;
                    // Standard UTF-8, one to three bytes
                    if (cp < 16'h0080) begin
                        add_result(data_k, cp[7:0]);
                    end else if (cp < 16'h0800) begin
                        add_result(data_k, UTF8_LEAD2 | {3'b000, cp[10:6]});
                        add_result(data_k, UTF8_CONT | {2'b00, cp[5:0]});
                    end else begin
                        add_result(data_k, UTF8_LEAD3 | {4'h0, cp[15:12]});
                        add_result(data_k, UTF8_CONT | {2'b00, cp[11:6]});
                        add_result(data_k, UTF8_CONT | {2'b00, cp[5:0]});
                    end
                end else begin
                    uhex_acc = cp;
                    uhex_cnt = uhex_cnt + 2'd1;
                end
            end
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] c);
        case (gram_ph)
            PH_OPEN: begin
                if (c == CH_LBRACE) gram_ph = PH_FIRST;
                else if (!is_blank(c)) grammar_error();
            end
            PH_FIRST: begin
                if (c == CH_RBRACE) gram_ph = PH_CLOSED;
                else if (c == CH_QUOTE) gram_ph = PH_KEY;
                else if (!is_blank(c)) grammar_error();
            end
            PH_KEY_QUOTE: begin
                if (c == CH_QUOTE) gram_ph = PH_KEY;
                else if (!is_blank(c)) grammar_error();
            end
            PH_KEY, PH_KEY_ESC, PH_KEY_HEX: string_byte(c, 1'b0);
            PH_COLON: begin
                if (c == CH_COLON) gram_ph = PH_VAL_QUOTE;
                else if (!is_blank(c)) grammar_error();
            end
            PH_VAL_QUOTE: begin
                if (c == CH_QUOTE) gram_ph = PH_VAL;
                else if (!is_blank(c)) grammar_error();
            end
            PH_VAL, PH_VAL_ESC, PH_VAL_HEX: string_byte(c, 1'b1);
            PH_SEP: begin
                if (c == CH_COMMA) begin
                    gram_ph = PH_KEY_QUOTE;
                    add_result(K_COMMIT, 8'h00);
                end else if (c == CH_RBRACE) begin
                    gram_ph = PH_CLOSED;
                    add_result(K_COMMIT, 8'h00);
                end else if (!is_blank(c)) begin
                    grammar_error();
                end
            end
            PH_CLOSED: begin
                if (!is_blank(c)) grammar_error();
            end
            default: ;  // dropping until the end mark
        endcase
    endfunction

    // Work out every result of one item into step_results, last one marked
    function automatic void parse_step(input logic [7:0] c, input logic p, input logic e);
        result_t r;
        step_results.delete();
        if (p) parse_byte(c);
        if (e) begin
            if (gram_ph == PH_CLOSED) add_result(K_OK, 8'h00);
            else if (gram_ph != PH_FAILED) add_result(K_ERROR, 8'h00);
            clear_tracker();
        end
        if (step_results.size() > 0) begin
            r = step_results[step_results.size() - 1];
            r.last = 1'b1;
            step_results[step_results.size() - 1] = r;
        end
    endfunction

    // ------------------------------------------------------------------
    // Text generation
    // ------------------------------------------------------------------

    // Append one byte to the text being built
    function automatic void append_char(input logic [7:0] c);
        text_q = {text_q, c};
    endfunction

    function automatic void put_blanks();
        int n;
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: append_char(CH_SPACE);
                1: append_char(CH_TAB);
                2: append_char(CH_LF);
                default: append_char(CH_CR);
            endcase
        end
    endfunction

    // A quoted string mixing printable bytes, raw bytes, escapes and \u escapes
    function automatic void put_string();
        int          n;
        logic [7:0]  c;
        logic [15:0] cp;
        logic [3:0]  nib;
        logic [7:0]  esc_set [8];
        esc_set = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_ESC_B,
                    CH_ESC_F, CH_ESC_N, CH_ESC_R, CH_ESC_T};
        append_char(CH_QUOTE);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    c = 8'($urandom_range(8'h20, 8'h7e));
                    if (c == CH_QUOTE || c == CH_BSLASH) c = 8'h61;
                    append_char(c);
                end
                5: begin
                    // any byte, zero and high bytes included
                    c = 8'($urandom_range(0, 255));
                    if (c == CH_QUOTE || c == CH_BSLASH) c = c ^ 8'h80;
                    append_char(c);
                end
                6, 7: begin
                    append_char(CH_BSLASH);
                    append_char(esc_set[$urandom_range(0, 7)]);
                end
                default: begin
                    append_char(CH_BSLASH);
                    append_char(CH_ESC_U);
                    // spread over the one-, two- and three-byte encodings
                    case ($urandom_range(0, 2))
                        0: cp = 16'($urandom_range(16'h0000, 16'h007f));
                        1: cp = 16'($urandom_range(16'h0080, 16'h07ff));
                        default: cp = 16'($urandom_range(16'h0800, 16'hffff));
                    endcase
                    for (int j = 3; j >= 0; j--) begin
                        nib = cp[j*4 +: 4];
                        if (nib < 4'd10) c = 8'h30 + nib;
                        else if ($urandom_range(0, 1)) c = 8'h37 + nib;
                        else c = 8'h57 + nib;
                        append_char(c);
                    end
                end
            endcase
        end
        append_char(CH_QUOTE);
    endfunction

    // Build a well-formed object, then break four texts in ten
    function automatic void build_text();
        int         np;
        int         pos;
        logic [7:0] c;
        text_q.delete();
        put_blanks();
        append_char(CH_LBRACE);
        np = $urandom_range(0, 3);
        for (int i = 0; i < np; i++) begin
            put_blanks();
            put_string();
            put_blanks();
            append_char(CH_COLON);
            put_blanks();
            put_string();
            put_blanks();
            if (i < np - 1) append_char(CH_COMMA);
        end
        put_blanks();
        append_char(CH_RBRACE);
        put_blanks();
        pos = $urandom_range(0, text_q.size() - 1);
        case ($urandom_range(0, 9))
            0: text_q[pos] = 8'($urandom_range(0, 255));
            1: while (text_q.size() > pos) void'(text_q.pop_back());
            2: begin
                // a stray structural byte: trailing commas, doubled braces
                case ($urandom_range(0, 4))
                    0: c = CH_COMMA;
                    1: c = CH_RBRACE;
                    2: c = CH_LBRACE;
                    3: c = CH_COLON;
                    default: c = CH_QUOTE;
                endcase
                text_q.insert(pos, c);
            end
            3: text_q.insert(pos, 8'($urandom_range(0, 255)));
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one item from a falling edge; return at the falling edge after its transfer
    task automatic send_item(input logic [7:0] b, input logic p, input logic e);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_in_byte      <= b;
        s_byte_present <= p;
        s_end_of_text  <= e;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        if (p || e) items_accepted++;
    endtask

    task automatic send_predicted(input logic [7:0] b, input logic p, input logic e);
        send_item(b, p, e);
        parse_step(b, p, e);
        pending_results = {pending_results, step_results};
    endtask

    // One generated text; the end mark rides on the last byte or comes alone
    task automatic send_text();
        logic with_byte;
        int   n;
        build_text();
        n = text_q.size();
        with_byte = (n > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < n; i++) begin
            // sprinkle empty items, which the block must ignore
            if ($urandom_range(0, 9) == 0) begin
                send_predicted(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            send_predicted(text_q[i], 1'b1, with_byte && (i == n - 1));
        end
        if (!with_byte) send_predicted(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        texts_sent++;
    endtask

    function automatic void add_row(input logic [7:0] b, input logic p, input logic e,
                                    input logic typed, input logic has,
                                    input kind_t k, input logic [7:0] d);
        drow_t r;
        r = '{b, p, e, typed, has, k, d};
        dir_rows = {dir_rows, r};
    endfunction

    // Receiver: stall at the rate of the current phase
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report(input string msg);
        fail_cnt++;
        // hold the log short if the block is badly broken
        if (fail_cnt <= 40) $display("[%0t] %s", $time, msg);
    endtask

    result_t seen_exp;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report($sformatf("result kind %0d byte %02h with nothing pending",
                                 m_result_kind, m_out_byte));
            end else begin
                seen_exp = pending_results.pop_front();
                results_checked++;
                if (seen_exp.kind == K_OK) ok_seen++;
                if (seen_exp.kind == K_ERROR) err_seen++;
                if (m_result_kind !== seen_exp.kind) begin
                    report($sformatf("result %0d kind %0d, want %0d",
                                     results_checked, m_result_kind, seen_exp.kind));
                end
                if (m_out_byte !== seen_exp.data) begin
                    report($sformatf("result %0d byte %02h, want %02h",
                                     results_checked, m_out_byte, seen_exp.data));
                end
                if (m_run_last !== seen_exp.last) begin
                    report($sformatf("result %0d run_last %0b, want %0b",
                                     results_checked, m_run_last, seen_exp.last));
                end
            end
        end
    end

    // Watchdog: end the run after too long without a transfer on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("No transfer for %0d cycles, %0d results still pending",
                         STALL_LIMIT, pending_results.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin
        int      target;
        result_t typed_r;

        clear_tracker();

        // Directed rows. Typed rows state their result outright; the rest are
        // predicted. Order matters: each row leaves the grammar where the next expects.
        add_row(8'h00,     1'b0, 1'b0, 1'b1, 1'b0, K_KEY_BYTE, 8'h00); // empty item
        add_row(8'h00,     1'b1, 1'b0, 1'b1, 1'b1, K_ERROR,    8'h00); // zero outside a string
        add_row(8'hff,     1'b1, 1'b0, 1'b1, 1'b0, K_KEY_BYTE, 8'h00); // dropped
        add_row(8'h00,     1'b0, 1'b1, 1'b1, 1'b0, K_KEY_BYTE, 8'h00); // end after error: silent
        add_row(CH_SPACE,  1'b1, 1'b0, 1'b1, 1'b0, K_KEY_BYTE, 8'h00);
        add_row(CH_LBRACE, 1'b1, 1'b0, 1'b1, 1'b0, K_KEY_BYTE, 8'h00);
        add_row(CH_QUOTE,  1'b1, 1'b0, 1'b1, 1'b0, K_KEY_BYTE, 8'h00);
        add_row(8'h00,     1'b1, 1'b0, 1'b1, 1'b1, K_KEY_BYTE, 8'h00); // zero inside a key
        add_row(8'hff,     1'b1, 1'b0, 1'b1, 1'b1, K_KEY_BYTE, 8'hff);
        add_row(CH_QUOTE,  1'b1, 1'b0, 1'b1, 1'b1, K_KEY_END,  8'h00);
        add_row(CH_COLON,  1'b1, 1'b0, 1'b0, 1'b0, K_KEY_BYTE, 8'h00);
        add_row(CH_QUOTE,  1'b1, 1'b0, 1'b0, 1'b0, K_KEY_BYTE, 8'h00);
        add_row(CH_BSLASH, 1'b1, 1'b0, 1'b0, 1'b0, K_KEY_BYTE, 8'h00);
        add_row(CH_ESC_U,  1'b1, 1'b0, 1'b0, 1'b0, K_KEY_BYTE, 8'h00);
        add_row(8'h46,     1'b1, 1'b0, 1'b0, 1'b0, K_KEY_BYTE, 8'h00); // \uFffF, mixed case
        add_row(8'h66,     1'b1, 1'b0, 1'b0, 1'b0, K_KEY_BYTE, 8'h00);
        add_row(8'h66,     1'b1, 1'b0, 1'b0, 1'b0, K_KEY_BYTE, 8'h00);
        add_row(8'h46,     1'b1, 1'b0, 1'b0, 1'b0, K_KEY_BYTE, 8'h00); // three UTF-8 bytes
        add_row(CH_BSLASH, 1'b1, 1'b0, 1'b0, 1'b0, K_KEY_BYTE, 8'h00);
        add_row(CH_ESC_N,  1'b1, 1'b0, 1'b0, 1'b0, K_KEY_BYTE, 8'h00);
        add_row(CH_QUOTE,  1'b1, 1'b0, 1'b0, 1'b0, K_KEY_BYTE, 8'h00);
        add_row(CH_COMMA,  1'b1, 1'b0, 1'b0, 1'b0, K_KEY_BYTE, 8'h00); // pair commit
        add_row(CH_RBRACE, 1'b1, 1'b0, 1'b1, 1'b1, K_ERROR,    8'h00); // trailing comma
        add_row(8'h00,     1'b0, 1'b1, 1'b1, 1'b0, K_KEY_BYTE, 8'h00);
        add_row(CH_LBRACE, 1'b1, 1'b0, 1'b1, 1'b0, K_KEY_BYTE, 8'h00); // empty object
        add_row(CH_RBRACE, 1'b1, 1'b0, 1'b1, 1'b0, K_KEY_BYTE, 8'h00);
        add_row(CH_TAB,    1'b1, 1'b1, 1'b1, 1'b1, K_OK,       8'h00); // end with trailing blank
        add_row(CH_LBRACE, 1'b1, 1'b1, 1'b1, 1'b1, K_ERROR,    8'h00); // end before the close

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].b, dir_rows[i].p, dir_rows[i].e);
            parse_step(dir_rows[i].b, dir_rows[i].p, dir_rows[i].e);
            if (!dir_rows[i].typed) begin
                pending_results = {pending_results, step_results};
            end else if (dir_rows[i].has) begin
                typed_r.kind = dir_rows[i].k;
                typed_r.data = dir_rows[i].d;
                typed_r.last = 1'b1;
                pending_results = {pending_results, typed_r};
            end
        end

        // Random texts: no idling, sender idle, receiver stalling, both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 82; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 82; end
                default: begin src_idle_pct = 30; snk_stall_pct = 30; end
            endcase
            target = items_accepted + PHASE_ITEMS;
            while (items_accepted < target) send_text();
        end
        s_valid <= 1'b0;

        // Drain with the receiver always ready, then watch for strays
        snk_stall_pct = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d input transfers in %0d texts plus %0d directed rows.",
                 items_accepted, texts_sent, dir_rows.size());
        $display("Checked %0d results: %0d done-ok, %0d error statuses, %0d mismatches.",
                 results_checked, ok_seen, err_seen, fail_cnt);
        if (fail_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
